// ===== src/qdp_pkg.sv =====
package qdp_pkg;

    localparam int MAX_REDUCTION = 4096;
    localparam int CNT_W         = $clog2(MAX_REDUCTION + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ZP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEI_ZP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_UNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 3'd4;

    localparam logic [23:0] ALPHA_RESET = 24'd65536;

    // operand pairs for the shared multiplier
    localparam logic [2:0] MUL_ZZ = 3'd0;
    localparam logic [2:0] MUL_ZK = 3'd1;
    localparam logic [2:0] MUL_SW = 3'd2;
    localparam logic [2:0] MUL_WS = 3'd3;
    localparam logic [2:0] MUL_PA = 3'd4;
    localparam logic [2:0] MUL_BP = 3'd5;
    localparam logic [2:0] MUL_LO = 3'd6;
    localparam logic [2:0] MUL_HI = 3'd7;

    // epilogue datapath steps
    localparam logic [3:0] STEP_NONE  = 4'd0;
    localparam logic [3:0] STEP_LOAD  = 4'd1;
    localparam logic [3:0] STEP_SUB   = 4'd2;
    localparam logic [3:0] STEP_SHADD = 4'd3;
    localparam logic [3:0] STEP_ADDSH = 4'd4;
    localparam logic [3:0] STEP_MAG   = 4'd5;
    localparam logic [3:0] STEP_STLO  = 4'd6;
    localparam logic [3:0] STEP_QUOT  = 4'd7;
    localparam logic [3:0] STEP_NEG   = 4'd8;
    localparam logic [3:0] STEP_OUT   = 4'd9;

    typedef struct packed {
        logic       acc;
        logic [2:0] mul_sel;
        logic [3:0] step;
    } t_cmd;

    typedef struct packed {
        logic out_stall;
    } t_stat;

endpackage

// ===== src/qdp_in_if.sv =====
interface qdp_in_if;
    logic               valid;
    logic               ready;
    logic        [7:0]  src_byte;
    logic signed [7:0]  wei_byte;
    logic               last_k;
    logic        [31:0] scale_q;
    logic signed [31:0] bias_q;
    logic signed [31:0] prior_q;

    modport source (
        output valid, src_byte, wei_byte, last_k, scale_q, bias_q, prior_q,
        input  ready
    );

    modport sink (
        input  valid, src_byte, wei_byte, last_k, scale_q, bias_q, prior_q,
        output ready
    );
endinterface

// ===== src/qdp_out_if.sv =====
interface qdp_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] result_q;
    logic               saturated;

    modport source (
        output valid, result_q, saturated,
        input  ready
    );

    modport sink (
        input  valid, result_q, saturated,
        output ready
    );
endinterface

// ===== src/qdp_dp.sv =====
module qdp_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qdp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [qdp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  qdp_pkg::t_cmd                     i_cmd,
    output qdp_pkg::t_stat                    o_stat,
    input  logic        [7:0]                 i_src_byte,
    input  logic signed [7:0]                 i_wei_byte,
    input  logic        [31:0]                i_scale_q,
    input  logic signed [31:0]                i_bias_q,
    input  logic signed [31:0]                i_prior_q,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [47:0]                o_result_q,
    output logic                              o_saturated
);

    localparam logic signed [23:0] ALPHA_RESET_S = qdp_pkg::ALPHA_RESET;

    logic signed [8:0]  r_szp;
    logic signed [7:0]  r_wzp;
    logic               r_uns;
    logic signed [23:0] r_alpha;
    logic signed [23:0] r_beta;

    logic [31:0]                 r_psum;
    logic [23:0]                 r_ssum;
    logic [23:0]                 r_wsum;
    logic [qdp_pkg::CNT_W-1:0]   r_cnt;

    logic        [31:0] r_scale;
    logic signed [31:0] r_bias;
    logic signed [31:0] r_prior;

    logic signed [65:0] r_prod;
    logic signed [56:0] r_acc;
    logic               r_neg;
    logic [55:0]        r_mag;
    logic [63:0]        r_lo;
    logic [52:0]        r_q;
    logic signed [53:0] r_t;

    logic               r_out_valid;
    logic signed [47:0] r_result;
    logic               r_sat;

    logic signed [8:0]  w_s;
    logic signed [7:0]  w_w;
    logic signed [16:0] w_sw;
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [65:0] w_prod;
    logic signed [65:0] w_bp;
    logic signed [56:0] w_abs;
    logic [63:0]        w_q;
    logic               w_qclamp;
    logic [52:0]        w_qc;
    logic [53:0]        w_qx;
    logic signed [53:0] w_t;
    logic signed [54:0] w_r;
    logic               w_sat;
    logic signed [47:0] w_res;

    assign w_s  = r_uns ? {1'b0, i_src_byte} : {i_src_byte[7], i_src_byte};
    assign w_w  = i_wei_byte;
    assign w_sw = w_s * w_w;

    // shared multiplier operand select
    always_comb begin
        unique case (i_cmd.mul_sel)
            qdp_pkg::MUL_ZZ: begin
                w_ma = {{24{r_szp[8]}}, r_szp};
                w_mb = {{25{r_wzp[7]}}, r_wzp};
            end
            qdp_pkg::MUL_ZK: begin
                w_ma = {{16{r_prod[16]}}, r_prod[16:0]};
                w_mb = {{(33 - qdp_pkg::CNT_W){1'b0}}, r_cnt};
            end
            qdp_pkg::MUL_SW: begin
                w_ma = {{24{r_szp[8]}}, r_szp};
                w_mb = {{9{r_wsum[23]}}, r_wsum};
            end
            qdp_pkg::MUL_WS: begin
                w_ma = {{25{r_wzp[7]}}, r_wzp};
                w_mb = {{9{r_ssum[23]}}, r_ssum};
            end
            qdp_pkg::MUL_PA: begin
                w_ma = {r_psum[31], r_psum};
                w_mb = {{9{r_alpha[23]}}, r_alpha};
            end
            qdp_pkg::MUL_BP: begin
                w_ma = {{9{r_beta[23]}}, r_beta};
                w_mb = {r_prior[31], r_prior};
            end
            qdp_pkg::MUL_LO: begin
                w_ma = {1'b0, r_mag[31:0]};
                w_mb = {1'b0, r_scale};
            end
            qdp_pkg::MUL_HI: begin
                w_ma = {9'd0, r_mag[55:32]};
                w_mb = {1'b0, r_scale};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_bp   = r_prod >>> 16;
    assign w_abs  = r_acc[56] ? -r_acc : r_acc;

    // magnitude quotient, rounded away from zero for negative values
    assign w_q = {r_prod[55:0], 8'd0} + {24'd0, r_lo[63:24]}
               + {63'd0, (r_neg && (r_lo[23:0] != 24'd0))};
    assign w_qclamp = (w_q[63:53] != 11'd0) || (w_q[52] && (w_q[51:0] != 52'd0));
    assign w_qc = w_qclamp ? {1'b1, 52'd0} : w_q[52:0];

    assign w_qx = {1'b0, r_q};
    assign w_t  = r_neg ? (54'd0 - w_qx) : w_qx;

    assign w_r   = {r_t[53], r_t} + {{23{r_bias[31]}}, r_bias};
    assign w_sat = (w_r[54:47] != {8{w_r[54]}});
    assign w_res = w_sat ? (w_r[54] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : w_r[47:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_szp   <= '0;
            r_wzp   <= '0;
            r_uns   <= 1'b0;
            r_alpha <= ALPHA_RESET_S;
            r_beta  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qdp_pkg::CFG_SRC_ZP:  r_szp   <= i_cfg_data[8:0];
                qdp_pkg::CFG_WEI_ZP:  r_wzp   <= i_cfg_data[7:0];
                qdp_pkg::CFG_SRC_UNS: r_uns   <= i_cfg_data[0];
                qdp_pkg::CFG_ALPHA:   r_alpha <= i_cfg_data[23:0];
                qdp_pkg::CFG_BETA:    r_beta  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum <= '0;
            r_ssum <= '0;
            r_wsum <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.step == qdp_pkg::STEP_OUT) begin
            r_psum <= '0;
            r_ssum <= '0;
            r_wsum <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.acc) begin
            r_psum <= r_psum + {{15{w_sw[16]}}, w_sw};
            r_ssum <= r_ssum + {{15{w_s[8]}}, w_s};
            r_wsum <= r_wsum + {{16{w_w[7]}}, w_w};
            if (r_cnt < qdp_pkg::CNT_W'(qdp_pkg::MAX_REDUCTION)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_scale <= i_scale_q;
            r_bias  <= i_bias_q;
            r_prior <= i_prior_q;
        end
        r_prod <= w_prod;
        unique case (i_cmd.step)
            qdp_pkg::STEP_LOAD:  r_acc <= r_prod[56:0];
            qdp_pkg::STEP_SUB:   r_acc <= r_acc - r_prod[56:0];
            qdp_pkg::STEP_SHADD: r_acc <= (r_acc <<< 16) + r_prod[56:0];
            qdp_pkg::STEP_ADDSH: r_acc <= r_acc + w_bp[56:0];
            qdp_pkg::STEP_MAG: begin
                r_neg <= r_acc[56];
                r_mag <= w_abs[55:0];
            end
            qdp_pkg::STEP_STLO:  r_lo <= r_prod[63:0];
            qdp_pkg::STEP_QUOT:  r_q  <= w_qc;
            qdp_pkg::STEP_NEG:   r_t  <= w_t;
            qdp_pkg::STEP_OUT: begin
                r_result <= w_res;
                r_sat    <= w_sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step == qdp_pkg::STEP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_stall = r_out_valid & ~i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_result_q       = r_result;
    assign o_saturated      = r_sat;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= qdp_pkg::CNT_W'(qdp_pkg::MAX_REDUCTION))
        else $error("pair count above limit");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == qdp_pkg::STEP_OUT) |=>
        (r_psum == 32'd0 && r_ssum == 24'd0 && r_wsum == 24'd0 && r_cnt == '0))
        else $error("accumulators not cleared after result");

    a_out_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == qdp_pkg::STEP_OUT) |=> o_out_valid)
        else $error("result written but not presented");

endmodule

// ===== src/qdp_ctrl.sv =====
module qdp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  qdp_pkg::t_stat i_stat,
    output qdp_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ZZ   = 4'd1;
    localparam logic [3:0] S_ZK   = 4'd2;
    localparam logic [3:0] S_SW   = 4'd3;
    localparam logic [3:0] S_WS   = 4'd4;
    localparam logic [3:0] S_PA   = 4'd5;
    localparam logic [3:0] S_BP   = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_MAG  = 4'd8;
    localparam logic [3:0] S_LO   = 4'd9;
    localparam logic [3:0] S_HI   = 4'd10;
    localparam logic [3:0] S_Q    = 4'd11;
    localparam logic [3:0] S_T    = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.acc     = 1'b0;
        o_cmd.mul_sel = qdp_pkg::MUL_ZZ;
        o_cmd.step    = qdp_pkg::STEP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.acc  = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_ZZ;
                end
            end
            S_ZZ: begin
                o_cmd.mul_sel = qdp_pkg::MUL_ZZ;
                n_state       = S_ZK;
            end
            S_ZK: begin
                o_cmd.mul_sel = qdp_pkg::MUL_ZK;
                n_state       = S_SW;
            end
            S_SW: begin
                o_cmd.mul_sel = qdp_pkg::MUL_SW;
                o_cmd.step    = qdp_pkg::STEP_LOAD;
                n_state       = S_WS;
            end
            S_WS: begin
                o_cmd.mul_sel = qdp_pkg::MUL_WS;
                o_cmd.step    = qdp_pkg::STEP_SUB;
                n_state       = S_PA;
            end
            S_PA: begin
                o_cmd.mul_sel = qdp_pkg::MUL_PA;
                o_cmd.step    = qdp_pkg::STEP_SUB;
                n_state       = S_BP;
            end
            S_BP: begin
                o_cmd.mul_sel = qdp_pkg::MUL_BP;
                o_cmd.step    = qdp_pkg::STEP_SHADD;
                n_state       = S_ADD;
            end
            S_ADD: begin
                o_cmd.step = qdp_pkg::STEP_ADDSH;
                n_state    = S_MAG;
            end
            S_MAG: begin
                o_cmd.step = qdp_pkg::STEP_MAG;
                n_state    = S_LO;
            end
            S_LO: begin
                o_cmd.mul_sel = qdp_pkg::MUL_LO;
                n_state       = S_HI;
            end
            S_HI: begin
                o_cmd.mul_sel = qdp_pkg::MUL_HI;
                o_cmd.step    = qdp_pkg::STEP_STLO;
                n_state       = S_Q;
            end
            S_Q: begin
                o_cmd.step = qdp_pkg::STEP_QUOT;
                n_state    = S_T;
            end
            S_T: begin
                o_cmd.step = qdp_pkg::STEP_NEG;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.out_stall) begin
                    o_cmd.step = qdp_pkg::STEP_OUT;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_last) |=> !o_in_ready)
        else $error("input taken during epilogue");

    a_epilogue_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ZZ) |-> ##12 (r_state == S_FIN))
        else $error("epilogue sequence broken");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step == qdp_pkg::STEP_OUT) |=> o_in_ready)
        else $error("not ready after result written");

endmodule

// ===== src/int8_quantized_dot_product.sv =====
// int8 dot product with zero-point compensation and a fixed-point epilogue.
// Each transaction on i_in carries one (source, weight) pair; the pair marked
// last_k closes the run, and its scale_q, bias_q and prior_q feed the epilogue.
// After a last pair the input stays not ready while the epilogue runs its steps
// through one shared 33x33 signed multiplier and a 57-bit accumulator. The
// finished result sits in an output register; pairs of the next run are
// accepted while it waits, and the next epilogue holds at its last step until
// that register is free. The user must write configuration registers through
// i_cfg_* only while no run is in progress; the block does not enforce it.
module int8_quantized_dot_product (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [qdp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qdp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    qdp_in_if.sink                         i_in,
    qdp_out_if.source                      o_out
);

    qdp_pkg::t_cmd  w_cmd;
    qdp_pkg::t_stat w_stat;

    qdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_k),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    qdp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_src_byte  (i_in.src_byte),
        .i_wei_byte  (i_in.wei_byte),
        .i_scale_q   (i_in.scale_q),
        .i_bias_q    (i_in.bias_q),
        .i_prior_q   (i_in.prior_q),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_result_q  (o_out.result_q),
        .o_saturated (o_out.saturated)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int          DRAIN_CYCLES   = 20;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLDOFF_CYCLES = 300;
    localparam int          LONG_RUN_PAIRS = 200;
    localparam int          RANDOM_PHASES  = 6;
    localparam int          PHASE_PAIRS    = 80;
    localparam longint      RESULT_MAX     = (longint'(1) <<< 47) - 1;
    localparam longint      RESULT_MIN     = -(longint'(1) <<< 47);
    localparam logic [95:0] QUOT_CLAMP     = 96'd1 << 52;

    typedef struct {
        logic        [7:0]  src_byte;
        logic signed [7:0]  wei_byte;
        logic               last_k;
        logic        [31:0] scale_q;
        logic signed [31:0] bias_q;
        logic signed [31:0] prior_q;
    } t_pair;

    typedef struct {
        logic [47:0] result_q;
        logic        saturated;
    } t_element;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [qdp_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [qdp_pkg::CFG_DATA_W-1:0] i_cfg_data;

    qdp_in_if  in_if ();
    qdp_out_if out_if ();

    int8_quantized_dot_product dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    logic [8:0]       cfg_szp   = '0;
    logic [7:0]       cfg_wzp   = '0;
    logic             cfg_uns   = 1'b0;
    logic [23:0]      cfg_alpha = qdp_pkg::ALPHA_RESET;
    logic [23:0]      cfg_beta  = '0;

    logic [31:0]               product_sum = '0;
    logic [23:0]               source_sum  = '0;
    logic [23:0]               weight_sum  = '0;
    logic [qdp_pkg::CNT_W-1:0] pair_count  = '0;

    t_pair    pair_queue[$];
    t_element expected_elements[$];

    bit idle_on      = 1'b1;
    bit hold_armed   = 1'b0;
    bit holdoff_done = 1'b0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int fail_count   = 0;

    always #5 i_clk = ~i_clk;

    function automatic t_element close_element(t_pair p);
        longint      szp, wzp, wsum, ssum, cnt, comp;
        longint      ps, alpha, beta, prior, acc, t, r;
        logic [63:0] mag;
        logic [95:0] prod, quot;
        logic        neg;
        t_element    e;
        szp   = $signed(cfg_szp);
        wzp   = $signed(cfg_wzp);
        wsum  = $signed(weight_sum);
        ssum  = $signed(source_sum);
        cnt   = pair_count;
        comp  = -szp * wsum - wzp * ssum + szp * wzp * cnt;
        ps    = $signed(product_sum);
        alpha = $signed(cfg_alpha);
        beta  = $signed(cfg_beta);
        prior = p.prior_q;
        acc   = ps * alpha + ((beta * prior) >>> 16) + comp * 65536;
        neg   = acc < 0;
        mag   = neg ? -acc : acc;
        prod  = mag * p.scale_q;
        quot  = prod >> 24;
        // negative values round toward minus infinity
        if (neg && prod[23:0] != '0) begin
            quot = quot + 1;
        end
        if (quot > QUOT_CLAMP) begin
            quot = QUOT_CLAMP;
        end
        t = quot[63:0];
        if (neg) begin
            t = -t;
        end
        r = t + p.bias_q;
        e.saturated = 1'b0;
        if (r > RESULT_MAX) begin
            r = RESULT_MAX;
            e.saturated = 1'b1;
        end else if (r < RESULT_MIN) begin
            r = RESULT_MIN;
            e.saturated = 1'b1;
        end
        e.result_q = r[47:0];
        return e;
    endfunction

    task automatic accumulate_pair(t_pair p);
        longint s, w;
        if (cfg_uns) begin
            s = p.src_byte;
        end else begin
            s = $signed(p.src_byte);
        end
        w = p.wei_byte;
        product_sum = product_sum + 32'(s * w);
        source_sum  = source_sum + 24'(s);
        weight_sum  = weight_sum + 24'(w);
        if (pair_count < qdp_pkg::MAX_REDUCTION) begin
            pair_count = pair_count + 1'b1;
        end
        if (p.last_k) begin
            expected_elements.push_back(close_element(p));
            product_sum = '0;
            source_sum  = '0;
            weight_sum  = '0;
            pair_count  = '0;
        end
    endtask

    task automatic write_reg(input logic [qdp_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [qdp_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            qdp_pkg::CFG_SRC_ZP:  cfg_szp   = data[8:0];
            qdp_pkg::CFG_WEI_ZP:  cfg_wzp   = data[7:0];
            qdp_pkg::CFG_SRC_UNS: cfg_uns   = data[0];
            qdp_pkg::CFG_ALPHA:   cfg_alpha = data[23:0];
            qdp_pkg::CFG_BETA:    cfg_beta  = data[23:0];
            default: ;
        endcase
    endtask

    task automatic add_pair(input logic [7:0] src, input logic signed [7:0] wei, input logic last,
                            input logic [31:0] scale, input logic [31:0] bias,
                            input logic [31:0] prior);
        t_pair p;
        p.src_byte = src;
        p.wei_byte = wei;
        p.last_k   = last;
        p.scale_q  = scale;
        p.bias_q   = bias;
        p.prior_q  = prior;
        pair_queue.push_back(p);
    endtask

    function automatic t_pair random_pair(logic last);
        t_pair p;
        p.src_byte = 8'($urandom);
        p.wei_byte = 8'($urandom);
        p.last_k   = last;
        case ($urandom_range(0, 3))
            0: p.scale_q = $urandom;
            1: p.scale_q = $urandom_range(0, 1 << 25);
            2: p.scale_q = $urandom_range(0, 1 << 20);
            default: p.scale_q = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
        p.bias_q  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20);
        p.prior_q = $urandom;
        return p;
    endfunction

    task automatic add_run(int len);
        for (int i = 0; i < len; i++) begin
            pair_queue.push_back(random_pair(i == len - 1));
        end
    endtask

    task automatic random_settings();
        logic [23:0] szp_data, wzp_data, alpha, beta;
        szp_data = 24'($urandom);
        wzp_data = 24'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            szp_data[8:0] = '0;
        end
        if ($urandom_range(0, 3) == 0) begin
            wzp_data[7:0] = '0;
        end
        alpha = $urandom_range(0, 1) ? 24'($urandom)
                                     : 24'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
        case ($urandom_range(0, 2))
            0: beta = '0;
            1: beta = 24'($urandom);
            default: beta = 24'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
        write_reg(qdp_pkg::CFG_SRC_ZP, szp_data);
        write_reg(qdp_pkg::CFG_WEI_ZP, wzp_data);
        write_reg(qdp_pkg::CFG_SRC_UNS, 24'($urandom));
        write_reg(qdp_pkg::CFG_ALPHA, alpha);
        write_reg(qdp_pkg::CFG_BETA, beta);
        if ($urandom_range(0, 1)) begin
            write_reg(qdp_pkg::CFG_IDX_W'($urandom_range(qdp_pkg::CFG_BETA + 1,
                                                         (1 << qdp_pkg::CFG_IDX_W) - 1)),
                      24'($urandom));
        end
    endtask

    // wait until every queued pair is in and every element has come out
    task automatic settle();
        while (pair_queue.size() != 0 || in_if.valid || expected_elements.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // pair driver
    always @(posedge i_clk) begin
        t_pair nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap    <= 0;
        end else if (!(in_if.valid && !in_if.ready)) begin
            if (send_gap != 0) begin
                send_gap    <= send_gap - 1;
                in_if.valid <= 1'b0;
            end else if (pair_queue.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
                send_gap    <= $urandom_range(0, 14);
                in_if.valid <= 1'b0;
            end else if (pair_queue.size() != 0) begin
                nxt = pair_queue.pop_front();
                in_if.valid    <= 1'b1;
                in_if.src_byte <= nxt.src_byte;
                in_if.wei_byte <= nxt.wei_byte;
                in_if.last_k   <= nxt.last_k;
                in_if.scale_q  <= nxt.scale_q;
                in_if.bias_q   <= nxt.bias_q;
                in_if.prior_q  <= nxt.prior_q;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // pair monitor
    always @(posedge i_clk) begin
        t_pair got;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            got.src_byte = in_if.src_byte;
            got.wei_byte = in_if.wei_byte;
            got.last_k   = in_if.last_k;
            got.scale_q  = in_if.scale_q;
            got.bias_q   = in_if.bias_q;
            got.prior_q  = in_if.prior_q;
            accumulate_pair(got);
        end
    end

    // element receiver and checker
    always @(posedge i_clk) begin
        t_element want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_gap     <= 0;
            hold_left    <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_elements.size() == 0) begin
                    $error("unexpected transaction: result_q %0d", out_if.result_q);
                    fail_count++;
                end else begin
                    want = expected_elements.pop_front();
                    if (out_if.result_q !== want.result_q) begin
                        $error("result_q mismatch: expected %0d, actual %0d",
                               $signed(want.result_q), out_if.result_q);
                        fail_count++;
                    end
                    if (out_if.saturated !== want.saturated) begin
                        $error("saturated mismatch: expected %0b, actual %0b",
                               want.saturated, out_if.saturated);
                        fail_count++;
                    end
                end
            end
            // long hold-off so that the block backs up into its input
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else if (hold_armed && !holdoff_done && pair_queue.size() > 50) begin
                hold_left    <= HOLDOFF_CYCLES;
                holdoff_done <= 1'b1;
                out_if.ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap     <= recv_gap - 1;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                recv_gap     <= $urandom_range(0, 14);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("** int8_quantized_dot_product: FAILED **");
            $finish;
        end
    end

    initial begin
        int total, len;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        in_if.valid    = 1'b0;
        in_if.src_byte = '0;
        in_if.wei_byte = '0;
        in_if.last_k   = 1'b0;
        in_if.scale_q  = '0;
        in_if.bias_q   = '0;
        in_if.prior_q  = '0;
        out_if.ready   = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, field extremes
        add_pair(8'h80, -8'sd128, 1'b1, 32'h0100_0000, 32'h0, 32'h0);
        add_pair(8'h7F, 8'sd127, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_pair(8'hFF, -8'sd1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_pair(8'h01, 8'sd127, 1'b1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
        settle();

        // unsigned source, largest alpha, most negative beta: both saturation ends
        write_reg(qdp_pkg::CFG_SRC_ZP, 24'hABC0FF);
        write_reg(qdp_pkg::CFG_WEI_ZP, 24'h5A5A80);
        write_reg(qdp_pkg::CFG_SRC_UNS, 24'hFFFFFF);
        write_reg(qdp_pkg::CFG_ALPHA, 24'h7FFFFF);
        write_reg(qdp_pkg::CFG_BETA, 24'h800000);
        for (int i = 0; i < 6; i++) begin
            add_pair(8'hFF, 8'sd127, i == 5, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        end
        for (int i = 0; i < 6; i++) begin
            add_pair(8'hFF, -8'sd128, i == 5, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        end
        add_pair(8'h00, 8'sd0, 1'b1, 32'h0, 32'h1234_5678, 32'h8765_4321);
        settle();

        // zero point below its stated range, most negative alpha, largest beta
        write_reg(qdp_pkg::CFG_SRC_ZP, 24'h000180);
        write_reg(qdp_pkg::CFG_WEI_ZP, 24'h00007F);
        write_reg(qdp_pkg::CFG_SRC_UNS, 24'hFFFFFE);
        write_reg(qdp_pkg::CFG_ALPHA, 24'h800000);
        write_reg(qdp_pkg::CFG_BETA, 24'h7FFFFF);
        write_reg(qdp_pkg::CFG_IDX_W'(qdp_pkg::CFG_BETA + 1), 24'hFFFFFF);
        add_pair(8'h80, -8'sd128, 1'b1, 32'h0100_0000, 32'h0, 32'h8000_0000);
        add_pair(8'h7F, 8'sd127, 1'b0, 32'h0, 32'h0, 32'h0);
        add_pair(8'h80, 8'sd127, 1'b1, 32'h0080_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        settle();

        // one long run with the largest per-pair terms
        write_reg(qdp_pkg::CFG_SRC_ZP, 24'($urandom_range(1, 511)));
        write_reg(qdp_pkg::CFG_WEI_ZP, 24'($urandom_range(1, 255)));
        write_reg(qdp_pkg::CFG_SRC_UNS, 24'h000001);
        write_reg(qdp_pkg::CFG_ALPHA, 24'($urandom));
        write_reg(qdp_pkg::CFG_BETA, 24'($urandom));
        for (int i = 0; i < LONG_RUN_PAIRS; i++) begin
            add_pair(8'hFF, -8'sd128, i == LONG_RUN_PAIRS - 1, $urandom, $urandom, $urandom);
        end
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == RANDOM_PHASES - 1) begin
                idle_on = 1'b0;
            end
            random_settings();
            total = 0;
            while (total < PHASE_PAIRS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 8);
                add_run(len);
                total += len;
            end
            if (ph == 0) begin
                hold_armed = 1'b1;
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("** int8_quantized_dot_product: PASSED **");
        end else begin
            $display("** int8_quantized_dot_product: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/qdp_pkg.sv
src/qdp_in_if.sv
src/qdp_out_if.sv
src/qdp_dp.sv
src/qdp_ctrl.sv
src/int8_quantized_dot_product.sv
test/tb.sv
